// ===== sv/fan_curve_with_hysteresis_core_defines.svh =====
// Assertion macros shared by the fan curve core.
// Depends on nothing; taken in by the top level with an include.
`ifndef FAN_CURVE_WITH_HYSTERESIS_CORE_DEFINES_SVH
`define FAN_CURVE_WITH_HYSTERESIS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fan curve core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FCH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fan curve core: next-cycle check failed");

`endif

// ===== sv/fch_pkg.sv =====
// Shared widths, reset values, codes, types and curve helpers of the fan curve core.
// Depends on nothing; every other file of the core but the defines header imports it.
`default_nettype none

package fch_pkg;

   localparam int FCH_RAW_W        = 8;
   localparam int FCH_TEMP_W       = 7;
   localparam int FCH_FAN_W        = 7;
   localparam int FCH_FRAC_W       = 8;
   localparam int FCH_SMOOTH_W     = 16;
   localparam int FCH_TABLE_W      = 35;
   localparam int FCH_WEIGHT_W     = 9;
   localparam int FCH_REPORT_W     = 8;
   localparam int FCH_CSR_IDX_W    = 3;
   localparam int FCH_CSR_DATA_W   = 35;
   localparam int FCH_CURVE_POINTS = 5;
   localparam int FCH_MAX_POINTS   = 8;
   localparam int FCH_SEG_W        = $clog2(FCH_MAX_POINTS - 1);
   localparam int FCH_DIV_K_W      = $clog2(FCH_FAN_W);
   localparam int FCH_SCALED_W     = FCH_TEMP_W + FCH_FRAC_W;
   localparam int FCH_MUL_A_W      = 18;
   localparam int FCH_MUL_B_W      = 10;
   localparam int FCH_ACC_W        = FCH_MUL_A_W + FCH_MUL_B_W;

   localparam logic [FCH_TEMP_W-1:0]   FCH_TOP_TEMP       = 7'd100;
   localparam logic [FCH_TEMP_W-1:0]   FCH_RST_TEMP_TWO   = 7'd55;
   localparam logic [FCH_TEMP_W-1:0]   FCH_RST_TEMP_THREE = 7'd70;
   localparam logic [FCH_TEMP_W-1:0]   FCH_RST_TEMP_FOUR  = 7'd80;
   localparam logic [FCH_TABLE_W-1:0]  FCH_RST_FAN_TABLE  = 35'd26906591872;
   localparam logic [FCH_TEMP_W-1:0]   FCH_RST_HYSTERESIS = 7'd3;
   localparam logic [FCH_WEIGHT_W-1:0] FCH_RST_WEIGHT     = 9'd26;
   localparam logic [FCH_WEIGHT_W-1:0] FCH_WEIGHT_ONE     = 9'd256;
   localparam logic [FCH_REPORT_W-1:0] FCH_NONE_REPORTED  = 8'hFF;

   typedef enum logic [FCH_CSR_IDX_W-1:0] {
      CSR_TEMP_TWO     = 3'd0,
      CSR_TEMP_THREE   = 3'd1,
      CSR_TEMP_FOUR    = 3'd2,
      CSR_FAN_TABLE    = 3'd3,
      CSR_HYSTERESIS   = 3'd4,
      CSR_SMOOTH_WEIGHT = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SMOOTH,
      ST_BLEND,
      ST_CHECK,
      ST_SEARCH,
      ST_MUL_BASE,
      ST_MUL_SLOPE,
      ST_DIVIDE,
      ST_STORE,
      ST_REPORT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_MUL_SMOOTH,
      DP_BLEND,
      DP_MARK,
      DP_MUL_BASE,
      DP_MUL_SLOPE,
      DP_DIV_STEP,
      DP_STORE,
      DP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type              op;
      logic [FCH_SEG_W-1:0]   seg;
      logic [FCH_DIV_K_W-1:0] div_k;
   } dp_cmd_type;

   typedef struct packed {
      logic reeval;
      logic seg_hit;
      logic rsp_free;
   } dp_status_type;

   // Temperature of curve point idx in whole degrees.
   function automatic logic [FCH_TEMP_W-1:0] curve_temp(
      input int unsigned            idx,
      input int unsigned            points,
      input logic [FCH_TEMP_W-1:0]  p2,
      input logic [FCH_TEMP_W-1:0]  p3,
      input logic [FCH_TEMP_W-1:0]  p4
   );
      logic [FCH_TEMP_W-1:0] t;
      if (idx == 0) begin
         t = '0;
      end else if (idx >= points - 1) begin
         t = FCH_TOP_TEMP;
      end else begin
         case (idx)
            1:       t = p2;
            2:       t = p3;
            3:       t = p4;
            default: t = FCH_TOP_TEMP;
         endcase
      end
      return t;
   endfunction

   // Fan percent of curve point idx; points past the table use its last field.
   function automatic logic [FCH_FAN_W-1:0] curve_fan(
      input int unsigned            idx,
      input logic [FCH_TABLE_W-1:0] fan_table
   );
      logic [FCH_FAN_W-1:0] f;
      case (idx)
         0:       f = fan_table[6:0];
         1:       f = fan_table[13:7];
         2:       f = fan_table[20:14];
         3:       f = fan_table[27:21];
         default: f = fan_table[34:28];
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

// ===== sv/fch_req_if.sv =====
// Request channel of the fan curve core: one raw temperature sample.
// Depends on fch_pkg.
`default_nettype none

interface fch_req_if;
   import fch_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FCH_RAW_W-1:0] raw_temp;

   modport source (output valid, output raw_temp, input ready);
   modport sink   (input valid, input raw_temp, output ready);
endinterface

`default_nettype wire

// ===== sv/fch_rsp_if.sv =====
// Response channel of the fan curve core: fan percent, smoothed temperature, change flag.
// Depends on fch_pkg.
`default_nettype none

interface fch_rsp_if;
   import fch_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FCH_FAN_W-1:0]    fan_percent;
   logic [FCH_SMOOTH_W-1:0] smoothed_temp;
   logic                    speed_changed;

   modport source (output valid, output fan_percent, output smoothed_temp,
                   output speed_changed, input ready);
   modport sink   (input valid, input fan_percent, input smoothed_temp,
                   input speed_changed, output ready);
endinterface

`default_nettype wire

// ===== sv/fch_csr_if.sv =====
// Register write channel of the fan curve core: register index and write data.
// Depends on fch_pkg.
`default_nettype none

interface fch_csr_if;
   import fch_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FCH_CSR_IDX_W-1:0]  index;
   logic [FCH_CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/fch_datapath.sv =====
// Datapath of the fan curve core: registers, smoother, shared multiplier, divider.
// Depends on fch_pkg; driven by fch_controller through command and status structs.
`default_nettype none

module fch_datapath #(
   parameter int CURVE_POINTS = fch_pkg::FCH_CURVE_POINTS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire fch_pkg::dp_cmd_type                 cmd,
   output fch_pkg::dp_status_type                   status,
   input  wire logic [fch_pkg::FCH_RAW_W-1:0]       req_raw_temp,
   input  wire logic                                csr_write,
   input  wire logic [fch_pkg::FCH_CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fch_pkg::FCH_CSR_DATA_W-1:0]  csr_data,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [fch_pkg::FCH_FAN_W-1:0]            rsp_fan_percent,
   output logic [fch_pkg::FCH_SMOOTH_W-1:0]         rsp_smoothed_temp,
   output logic                                     rsp_speed_changed
);
   import fch_pkg::*;

   // Register bank.
   logic [FCH_TEMP_W-1:0]   temp_two_ff, temp_two_in;
   logic [FCH_TEMP_W-1:0]   temp_three_ff, temp_three_in;
   logic [FCH_TEMP_W-1:0]   temp_four_ff, temp_four_in;
   logic [FCH_TABLE_W-1:0]  fan_table_ff, fan_table_in;
   logic [FCH_TEMP_W-1:0]   hyst_ff, hyst_in;
   logic [FCH_WEIGHT_W-1:0] weight_ff, weight_in;

   // Controller state kept between requests.
   logic [FCH_SMOOTH_W-1:0] smooth_ff, smooth_in;
   logic                    primed_ff, primed_in;
   logic [FCH_SMOOTH_W-1:0] last_eval_ff, last_eval_in;
   logic [FCH_FAN_W-1:0]    held_ff, held_in;
   logic [FCH_REPORT_W-1:0] last_rep_ff, last_rep_in;

   // Working registers of one request.
   logic [FCH_RAW_W-1:0]    sample_ff, sample_in;
   logic [FCH_ACC_W-1:0]    acc_ff, acc_in;
   logic [FCH_FAN_W-1:0]    quot_ff, quot_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FCH_FAN_W-1:0]    rsp_fan_ff, rsp_fan_in;
   logic [FCH_SMOOTH_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic                    rsp_chg_ff, rsp_chg_in;

   logic [FCH_WEIGHT_W-1:0] weight_eff;
   logic [FCH_SMOOTH_W-1:0] sample_q88;
   logic [FCH_SMOOTH_W:0]   sample_diff;
   logic [FCH_ACC_W-1:0]    blend_sum;

   logic [FCH_TEMP_W-1:0]   seg_lo_deg, seg_hi_deg;
   logic [FCH_SCALED_W-1:0] seg_lo, seg_hi, seg_den, seg_off;
   logic [FCH_FAN_W-1:0]    fan_lo, fan_hi;
   logic [FCH_FAN_W:0]      fan_step;

   logic signed [FCH_MUL_A_W-1:0] mul_a;
   logic signed [FCH_MUL_B_W-1:0] mul_b;
   logic signed [FCH_ACC_W-1:0]   product;

   logic [FCH_ACC_W-1:0]    div_trial;
   logic                    div_fits;

   // Register writes.
   always_comb begin
      temp_two_in   = temp_two_ff;
      temp_three_in = temp_three_ff;
      temp_four_in  = temp_four_ff;
      fan_table_in  = fan_table_ff;
      hyst_in       = hyst_ff;
      weight_in     = weight_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEMP_TWO:      temp_two_in   = csr_data[FCH_TEMP_W-1:0];
            CSR_TEMP_THREE:    temp_three_in = csr_data[FCH_TEMP_W-1:0];
            CSR_TEMP_FOUR:     temp_four_in  = csr_data[FCH_TEMP_W-1:0];
            CSR_FAN_TABLE:     fan_table_in  = csr_data[FCH_TABLE_W-1:0];
            CSR_HYSTERESIS:    hyst_in       = csr_data[FCH_TEMP_W-1:0];
            CSR_SMOOTH_WEIGHT: weight_in     = csr_data[FCH_WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Weights above one behave as one.
   assign weight_eff  = (weight_ff > FCH_WEIGHT_ONE) ? FCH_WEIGHT_ONE : weight_ff;
   assign sample_q88  = {sample_ff, {FCH_FRAC_W{1'b0}}};
   assign sample_diff = {1'b0, sample_q88} - {1'b0, smooth_ff};
   assign blend_sum   = {{(FCH_ACC_W - FCH_SMOOTH_W - FCH_FRAC_W){1'b0}}, smooth_ff,
                         {FCH_FRAC_W{1'b0}}} + acc_ff;

   // Segment selected by the controller, in Q7.8 degrees.
   assign seg_lo_deg = curve_temp(int'(cmd.seg), CURVE_POINTS,
                                  temp_two_ff, temp_three_ff, temp_four_ff);
   assign seg_hi_deg = curve_temp(int'(cmd.seg) + 1, CURVE_POINTS,
                                  temp_two_ff, temp_three_ff, temp_four_ff);
   assign seg_lo     = {seg_lo_deg, {FCH_FRAC_W{1'b0}}};
   assign seg_hi     = {seg_hi_deg, {FCH_FRAC_W{1'b0}}};
   assign seg_den    = seg_hi - seg_lo;
   assign seg_off    = smooth_ff[FCH_SCALED_W-1:0] - seg_lo;
   assign fan_lo     = curve_fan(int'(cmd.seg), fan_table_ff);
   assign fan_hi     = curve_fan(int'(cmd.seg) + 1, fan_table_ff);
   assign fan_step   = {1'b0, fan_hi} - {1'b0, fan_lo};

   // One shared signed multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         DP_MUL_SMOOTH: begin
            mul_a = {{(FCH_MUL_A_W - FCH_SMOOTH_W - 1){sample_diff[FCH_SMOOTH_W]}},
                     sample_diff};
            mul_b = {{(FCH_MUL_B_W - FCH_WEIGHT_W){1'b0}}, weight_eff};
         end
         DP_MUL_BASE: begin
            mul_a = {{(FCH_MUL_A_W - FCH_SCALED_W){1'b0}}, seg_den};
            mul_b = {{(FCH_MUL_B_W - FCH_FAN_W){1'b0}}, fan_lo};
         end
         DP_MUL_SLOPE: begin
            mul_a = {{(FCH_MUL_A_W - FCH_SCALED_W){1'b0}}, seg_off};
            mul_b = {{(FCH_MUL_B_W - FCH_FAN_W - 1){fan_step[FCH_FAN_W]}}, fan_step};
         end
         default: ;
      endcase
   end

   assign product = mul_a * mul_b;

   // Restoring division: one quotient bit per step, most significant first.
   assign div_trial = {{(FCH_ACC_W - FCH_SCALED_W){1'b0}}, seg_den} << cmd.div_k;
   assign div_fits  = (acc_ff >= div_trial);

   always_comb begin
      smooth_in    = smooth_ff;
      primed_in    = primed_ff;
      last_eval_in = last_eval_ff;
      held_in      = held_ff;
      last_rep_in  = last_rep_ff;
      sample_in    = sample_ff;
      acc_in       = acc_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_fan_in   = rsp_fan_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_chg_in   = rsp_chg_ff;
      case (cmd.op)
         DP_LOAD:       sample_in = req_raw_temp;
         DP_MUL_SMOOTH: acc_in    = $unsigned(product);
         DP_BLEND: begin
            smooth_in = primed_ff ? blend_sum[FCH_SMOOTH_W+FCH_FRAC_W-1:FCH_FRAC_W]
                                  : sample_q88;
            primed_in = 1'b1;
         end
         DP_MARK:       last_eval_in = smooth_ff;
         DP_MUL_BASE:   acc_in = $unsigned(product);
         DP_MUL_SLOPE: begin
            acc_in  = acc_ff + $unsigned(product);
            quot_in = '0;
         end
         DP_DIV_STEP: begin
            if (div_fits) begin
               acc_in = acc_ff - div_trial;
            end
            quot_in = {quot_ff[FCH_FAN_W-2:0], div_fits};
         end
         DP_STORE:      held_in = quot_ff;
         DP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_fan_in   = held_ff;
            rsp_temp_in  = smooth_ff;
            rsp_chg_in   = ({1'b0, held_ff} != last_rep_ff);
            last_rep_in  = {1'b0, held_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_two_ff   <= FCH_RST_TEMP_TWO;
         temp_three_ff <= FCH_RST_TEMP_THREE;
         temp_four_ff  <= FCH_RST_TEMP_FOUR;
         fan_table_ff  <= FCH_RST_FAN_TABLE;
         hyst_ff       <= FCH_RST_HYSTERESIS;
         weight_ff     <= FCH_RST_WEIGHT;
         smooth_ff     <= '0;
         primed_ff     <= 1'b0;
         last_eval_ff  <= '0;
         held_ff       <= '0;
         last_rep_ff   <= FCH_NONE_REPORTED;
         rsp_valid_ff  <= 1'b0;
      end else begin
         temp_two_ff   <= temp_two_in;
         temp_three_ff <= temp_three_in;
         temp_four_ff  <= temp_four_in;
         fan_table_ff  <= fan_table_in;
         hyst_ff       <= hyst_in;
         weight_ff     <= weight_in;
         smooth_ff     <= smooth_in;
         primed_ff     <= primed_in;
         last_eval_ff  <= last_eval_in;
         held_ff       <= held_in;
         last_rep_ff   <= last_rep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      acc_ff      <= acc_in;
      quot_ff     <= quot_in;
      rsp_fan_ff  <= rsp_fan_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_chg_ff  <= rsp_chg_in;
   end

   // Re-evaluate on any rise, or on a fall larger than the hysteresis.
   always_comb begin
      status.reeval   = (smooth_ff > last_eval_ff) ||
                        ((last_eval_ff > smooth_ff) &&
                         ((last_eval_ff - smooth_ff) > {1'b0, hyst_ff, {FCH_FRAC_W{1'b0}}}));
      status.seg_hit  = ({1'b0, seg_lo} <= smooth_ff) && (smooth_ff < {1'b0, seg_hi});
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fan_percent   = rsp_fan_ff;
   assign rsp_smoothed_temp = rsp_temp_ff;
   assign rsp_speed_changed = rsp_chg_ff;

endmodule

`default_nettype wire

// ===== sv/fch_controller.sv =====
// Sequencing state machine of the fan curve core.
// Depends on fch_pkg; commands fch_datapath and reads its status.
`default_nettype none

module fch_controller #(
   parameter int CURVE_POINTS = fch_pkg::FCH_CURVE_POINTS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire fch_pkg::dp_status_type status,
   output fch_pkg::dp_cmd_type         cmd
);
   import fch_pkg::*;

   localparam logic [FCH_SEG_W-1:0]   LAST_SEG = FCH_SEG_W'(CURVE_POINTS - 2);
   localparam logic [FCH_DIV_K_W-1:0] DIV_TOP  = FCH_DIV_K_W'(FCH_FAN_W - 1);

   ctrl_state_type         state_ff, state_in;
   logic [FCH_SEG_W-1:0]   seg_ff, seg_in;
   logic [FCH_DIV_K_W-1:0] div_k_ff, div_k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seg_ff   <= '0;
         div_k_ff <= '0;
      end else begin
         state_ff <= state_in;
         seg_ff   <= seg_in;
         div_k_ff <= div_k_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      seg_in    = seg_ff;
      div_k_in  = div_k_ff;
      req_ready = 1'b0;
      cmd.op    = DP_NOP;
      cmd.seg   = seg_ff;
      cmd.div_k = div_k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = ST_MUL_SMOOTH;
            end
         end
         ST_MUL_SMOOTH: begin
            cmd.op   = DP_MUL_SMOOTH;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.op   = DP_BLEND;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.reeval) begin
               cmd.op   = DP_MARK;
               seg_in   = '0;
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_SEARCH: begin
            if (status.seg_hit) begin
               state_in = ST_MUL_BASE;
            end else if (seg_ff == LAST_SEG) begin
               state_in = ST_REPORT;
            end else begin
               seg_in = seg_ff + 1'b1;
            end
         end
         ST_MUL_BASE: begin
            cmd.op   = DP_MUL_BASE;
            state_in = ST_MUL_SLOPE;
         end
         ST_MUL_SLOPE: begin
            cmd.op   = DP_MUL_SLOPE;
            div_k_in = DIV_TOP;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.op = DP_DIV_STEP;
            if (div_k_ff == '0) begin
               state_in = ST_STORE;
            end else begin
               div_k_in = div_k_ff - 1'b1;
            end
         end
         ST_STORE: begin
            cmd.op   = DP_STORE;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.rsp_free) begin
               cmd.op   = DP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/fan_curve_with_hysteresis_core.sv =====
// Top level of the fan curve core: controller, datapath, channel wiring and checks.
// Depends on fch_pkg, the three channel interfaces, fch_controller and fch_datapath.
//
//   Channel   Direction  Carries
//   req_port  in         raw_temp (whole degrees)
//   rsp_port  out        fan_percent, smoothed_temp (Q8.8), speed_changed
//   csr_port  in         index, data (register write, ready whenever out of reset)
//
// One request is in flight at a time; a new one is taken only once the last is reported.
// A request that does not re-evaluate the curve goes from smoothing and the hysteresis
// check straight to the report; one that re-evaluates also scans the segments from the
// first, and on a match multiplies and runs the seven-step divider before it is stored.
// Reset is synchronous and active high; both input channels are held not ready while it
// is high, and a request can be taken at the first rising edge after it falls.
// A stalled response holds in its register and the request channel stays ready for one
// more request, which then waits for the response register before it is delivered.
`include "fan_curve_with_hysteresis_core_defines.svh"
`default_nettype none

module fan_curve_with_hysteresis_core #(
   parameter int CURVE_POINTS = fch_pkg::FCH_CURVE_POINTS
) (
   input wire logic  clock,
   input wire logic  reset,
   fch_req_if.sink   req_port,
   fch_rsp_if.source rsp_port,
   fch_csr_if.sink   csr_port
);
   import fch_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          ctrl_req_ready;

   // The sequencer walks each request through smoothing, the hysteresis test, the
   // segment scan and the interpolation divide.
   fch_controller #(
      .CURVE_POINTS (CURVE_POINTS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (ctrl_req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // The datapath holds the register bank, the smoother and curve state, and the
   // response register that decouples the response channel from the sequencer.
   fch_datapath #(
      .CURVE_POINTS (CURVE_POINTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .req_raw_temp      (req_port.raw_temp),
      .csr_write         (csr_port.valid),
      .csr_index         (csr_port.index),
      .csr_data          (csr_port.data),
      .rsp_ready         (rsp_port.ready),
      .rsp_valid         (rsp_port.valid),
      .rsp_fan_percent   (rsp_port.fan_percent),
      .rsp_smoothed_temp (rsp_port.smoothed_temp),
      .rsp_speed_changed (rsp_port.speed_changed)
   );

   // Nothing is taken while reset is high, since the registers ignore it then.
   assign req_port.ready = ctrl_req_ready && !reset;

   // Register writes are taken in any cycle out of reset.
   assign csr_port.ready = !reset;

   // Once a request is taken the sequencer is busy for at least the following cycle.
   `FCH_ASSERT_NEXT(a_single_request, clock, reset, req_port.valid && req_port.ready, !req_port.ready)
   // A response is only loaded when the response register is free or being emptied.
   `FCH_ASSERT_NOW(a_emit_into_free_slot, clock, reset, dp_cmd.op == DP_EMIT, dp_status.rsp_free)
   // Loading a response always presents it on the channel in the next cycle.
   `FCH_ASSERT_NEXT(a_emit_shows_valid, clock, reset, dp_cmd.op == DP_EMIT, rsp_port.valid)

endmodule

`default_nettype wire

// ===== dv/fan_curve_with_hysteresis_core_test.sv =====
// Self-checking testbench of fan_curve_with_hysteresis_core: smoother, hysteresis and curve.
// Depends on fch_pkg, the request, response and register channel interfaces and the core.
// A scoreboard class predicts every response from the accepted requests and register writes.
`timescale 1ns / 100ps

module fan_curve_with_hysteresis_core_test;
   import fch_pkg::*;

   // One predicted response of the core.
   typedef struct packed {
      logic [FCH_FAN_W-1:0]    fan_percent;
      logic [FCH_SMOOTH_W-1:0] smoothed_temp;
      logic                    speed_changed;
   } fan_reading_type;

   // Tracks the controller state, works out the fan reading of every accepted request and
   // compares the core's responses against those readings in order.
   class fan_speed_scoreboard;
      logic [FCH_TEMP_W-1:0]   bp_two, bp_three, bp_four, hyst_deg;
      logic [FCH_TABLE_W-1:0]  fan_table;
      logic [FCH_WEIGHT_W-1:0] weight;
      logic [FCH_SMOOTH_W-1:0] smooth_q88, last_eval_q88;
      bit                      primed;
      logic [FCH_FAN_W-1:0]    held_percent;
      logic [FCH_REPORT_W-1:0] last_reported;
      fan_reading_type         expected_readings[$];
      int unsigned             mismatches;

      function new();
         bp_two        = FCH_RST_TEMP_TWO;
         bp_three      = FCH_RST_TEMP_THREE;
         bp_four       = FCH_RST_TEMP_FOUR;
         fan_table     = FCH_RST_FAN_TABLE;
         hyst_deg      = FCH_RST_HYSTERESIS;
         weight        = FCH_RST_WEIGHT;
         smooth_q88    = '0;
         last_eval_q88 = '0;
         primed        = 1'b0;
         held_percent  = '0;
         last_reported = FCH_NONE_REPORTED;
         mismatches    = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [FCH_CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TEMP_TWO:      bp_two    = data[FCH_TEMP_W-1:0];
            CSR_TEMP_THREE:    bp_three  = data[FCH_TEMP_W-1:0];
            CSR_TEMP_FOUR:     bp_four   = data[FCH_TEMP_W-1:0];
            CSR_FAN_TABLE:     fan_table = data[FCH_TABLE_W-1:0];
            CSR_HYSTERESIS:    hyst_deg  = data[FCH_TEMP_W-1:0];
            CSR_SMOOTH_WEIGHT: weight    = data[FCH_WEIGHT_W-1:0];
            default: ;
         endcase
      endfunction

      // Breakpoint temperature in whole degrees; the ends sit at 0 and 100 degrees.
      function longint point_temp(int i);
         if (i <= 0) return 0;
         if (i >= FCH_CURVE_POINTS - 1) return FCH_TOP_TEMP;
         case (i)
            1:       return bp_two;
            2:       return bp_three;
            3:       return bp_four;
            default: return FCH_TOP_TEMP;
         endcase
      endfunction

      function longint point_fan(int i);
         int k;
         k = (i > 4) ? 4 : i;
         return fan_table[7*k +: 7];
      endfunction

      // Finds the first segment holding t and floors the interpolated percent. A segment
      // whose end is not above its start never matches, and no match leaves the speed held.
      function void evaluate_curve(longint t);
         longint lo, hi, den, f0, f1, num;
         for (int i = 0; i < FCH_CURVE_POINTS - 1; i++) begin
            lo = point_temp(i) << 8;
            hi = point_temp(i + 1) << 8;
            if (t >= lo && t < hi) begin
               den = hi - lo;
               f0  = point_fan(i);
               f1  = point_fan(i + 1);
               num = f0 * den + (t - lo) * (f1 - f0);
               if (num < 0) num = 0;
               held_percent = FCH_FAN_W'(num / den);
               return;
            end
         end
      endfunction

      function void note_sample(logic [FCH_RAW_W-1:0] raw);
         longint          x, a, fall;
         fan_reading_type r;
         x = longint'(raw) << 8;
         a = (weight > FCH_WEIGHT_ONE) ? 256 : longint'(weight);
         if (!primed) begin
            smooth_q88 = x[FCH_SMOOTH_W-1:0];
            primed     = 1'b1;
         end else begin
            smooth_q88 = FCH_SMOOTH_W'((a * x + (256 - a) * longint'(smooth_q88)) >> 8);
         end
         fall = longint'(last_eval_q88) - longint'(smooth_q88);
         if (fall > (longint'(hyst_deg) << 8) || smooth_q88 > last_eval_q88) begin
            evaluate_curve(longint'(smooth_q88));
            last_eval_q88 = smooth_q88;
         end
         r.fan_percent   = held_percent;
         r.smoothed_temp = smooth_q88;
         r.speed_changed = ({1'b0, held_percent} != last_reported);
         last_reported   = {1'b0, held_percent};
         expected_readings.push_back(r);
      endfunction

      function void note_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
      endfunction

      function void check_reading(fan_reading_type got);
         fan_reading_type want;
         if (expected_readings.size() == 0) begin
            note_mismatch($sformatf("response with none pending: fan %0d smooth %h chg %0b",
                                    got.fan_percent, got.smoothed_temp, got.speed_changed));
            return;
         end
         want = expected_readings.pop_front();
         if (got.fan_percent !== want.fan_percent ||
             got.smoothed_temp !== want.smoothed_temp ||
             got.speed_changed !== want.speed_changed)
            note_mismatch($sformatf("expected fan %0d smooth %h chg %0b, got fan %0d smooth %h chg %0b",
                                    want.fan_percent, want.smoothed_temp, want.speed_changed,
                                    got.fan_percent, got.smoothed_temp, got.speed_changed));
      endfunction

      function int unsigned pending();
         return expected_readings.size();
      endfunction

      function void flush_leftovers();
         while (expected_readings.size() != 0) begin
            void'(expected_readings.pop_front());
            note_mismatch("expected response never arrived");
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on;

   fch_req_if req_if();
   fch_rsp_if rsp_if();
   fch_csr_if csr_if();

   fan_speed_scoreboard sb = new();

   fan_curve_with_hysteresis_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Give up well past the slowest legitimate run.
   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Every handshake is observed here at the rising edge. A response is checked before a
   // request at the same edge is noted, since it can only belong to an earlier request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_reading({rsp_if.fan_percent, rsp_if.smoothed_temp, rsp_if.speed_changed});
         if (req_if.valid && req_if.ready)
            sb.note_sample(req_if.raw_temp);
         if (csr_if.valid && csr_if.ready)
            sb.write_reg(csr_index_type'(csr_if.index), csr_if.data);
      end
   end

   // The response side stalls in bursts of random length while idling is switched on.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 17);
         end
      end
   end

   // Presents one sample, sometimes after an idle burst, and returns once it is accepted.
   // Valid is left high so that back-to-back requests need no extra cycle.
   task automatic send_sample(input logic [FCH_RAW_W-1:0] raw);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.raw_temp <= raw;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // Waits for every outstanding response, then for the longest evaluation to settle.
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [FCH_CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Packs five fan percents, point one in the low field.
   function automatic logic [FCH_TABLE_W-1:0] pack_fans(int f0, int f1, int f2, int f3, int f4);
      return {7'(f4), 7'(f3), 7'(f2), 7'(f1), 7'(f0)};
   endfunction

   // Setting 0 is every register at its minimum, 1 every register at its maximum; any
   // other setting is random, mostly a sensible rising curve and sometimes anything at all.
   task automatic load_setting(input int kind);
      int t[3];
      int f[5];
      int tmp;
      logic [FCH_TABLE_W-1:0] table_word;
      if (kind == 0) begin
         t = '{0, 0, 0};
         table_word = '0;
      end else if (kind == 1) begin
         t = '{127, 127, 127};
         table_word = '1;
      end else if ($urandom_range(0, 3) != 0) begin
         foreach (t[i]) t[i] = $urandom_range(1, 99);
         if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
         if (t[1] > t[2]) begin tmp = t[1]; t[1] = t[2]; t[2] = tmp; end
         if (t[0] > t[1]) begin tmp = t[0]; t[0] = t[1]; t[1] = tmp; end
         foreach (f[i]) f[i] = $urandom_range(0, 100);
         f.sort();
         if ($urandom_range(0, 3) == 0) f.reverse();
         table_word = pack_fans(f[0], f[1], f[2], f[3], f[4]);
      end else begin
         foreach (t[i]) t[i] = $urandom_range(0, 127);
         table_word = FCH_TABLE_W'({$urandom, $urandom});
      end
      write_reg(CSR_TEMP_TWO, t[0]);
      write_reg(CSR_TEMP_THREE, t[1]);
      write_reg(CSR_TEMP_FOUR, t[2]);
      write_reg(CSR_FAN_TABLE, table_word);
      case (kind)
         0:       write_reg(CSR_HYSTERESIS, 0);
         1:       write_reg(CSR_HYSTERESIS, 127);
         default: write_reg(CSR_HYSTERESIS, ($urandom_range(0, 3) != 0) ?
                                            $urandom_range(0, 10) : $urandom_range(0, 127));
      endcase
      case (kind)
         0:       write_reg(CSR_SMOOTH_WEIGHT, 0);
         1:       write_reg(CSR_SMOOTH_WEIGHT, 511);
         default: begin
            case ($urandom_range(0, 5))
               0:       write_reg(CSR_SMOOTH_WEIGHT, FCH_WEIGHT_ONE);
               1:       write_reg(CSR_SMOOTH_WEIGHT, $urandom_range(257, 511));
               2:       write_reg(CSR_SMOOTH_WEIGHT, $urandom_range(0, 511));
               default: write_reg(CSR_SMOOTH_WEIGHT, $urandom_range(8, 128));
            endcase
         end
      endcase
   endtask

   initial begin
      int temp_walk;
      reset          = 1'b1;
      idle_on        = 1'b1;
      req_if.valid   = 1'b0;
      req_if.raw_temp = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = '0;
      csr_if.data    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset curve: the first sample loads the smoother straight away and is always
      // reported as a change; then falls inside and beyond the hysteresis, and rises.
      send_sample(8'd40);
      send_sample(8'd0);
      send_sample(8'd255);
      send_sample(8'd100);
      send_sample(8'd99);
      send_sample(8'd1);
      send_sample(8'd128);
      send_sample(8'd60);
      end_burst();
      drain();

      // A weight above one acts as one, so the smoother follows each sample exactly; with
      // no hysteresis any fall re-evaluates. At and above 100 degrees no segment matches
      // and the speed holds while the evaluated temperature still moves.
      write_reg(CSR_SMOOTH_WEIGHT, 300);
      write_reg(CSR_HYSTERESIS, 0);
      send_sample(8'd255);
      send_sample(8'd100);
      send_sample(8'd75);
      send_sample(8'd74);
      send_sample(8'd0);
      end_burst();
      drain();

      // Breakpoints out of order make empty segments that must never match.
      write_reg(CSR_TEMP_TWO, 90);
      write_reg(CSR_TEMP_THREE, 30);
      write_reg(CSR_TEMP_FOUR, 30);
      write_reg(CSR_FAN_TABLE, pack_fans(127, 0, 127, 64, 100));
      send_sample(8'd20);
      send_sample(8'd50);
      send_sample(8'd95);
      send_sample(8'd29);
      send_sample(8'd30);

      // Random phases: the first two take the extreme settings and the last two run
      // with neither side idling. Temperatures mostly wander, with occasional jumps.
      temp_walk = 40;
      for (int phase = 0; phase < 12; phase++) begin
         end_burst();
         drain();
         idle_on = (phase >= 10) ? 1'b0 : ($urandom_range(0, 3) != 0);
         load_setting(phase);
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               temp_walk = $urandom_range(0, 255);
            end else begin
               temp_walk = temp_walk + $urandom_range(0, 12) - 6;
               if (temp_walk < 0) temp_walk = 0;
               if (temp_walk > 127) temp_walk = 110;
            end
            send_sample(temp_walk[FCH_RAW_W-1:0]);
         end
      end

      end_burst();
      drain();
      sb.flush_leftovers();
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fch_pkg.sv
sv/fch_req_if.sv
sv/fch_rsp_if.sv
sv/fch_csr_if.sv
sv/fch_datapath.sv
sv/fch_controller.sv
sv/fan_curve_with_hysteresis_core.sv
dv/fan_curve_with_hysteresis_core_test.sv
